// ===== sv/sfia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_pkg
// Shared constants, codes, types and helpers of the slab free-index allocator.
// ----------------------------------------------------------------------------
package sfia_pkg;

  localparam int MAX_SLOTS = 512;
  localparam int PAGE_BITS = 12;

  localparam int ADDR_W     = 64;
  localparam int PNUM_W     = 52;
  localparam int SIZE_W     = 13;
  localparam int SCNT_W     = 10;
  localparam int OFFS_W     = 12;
  localparam int KIND_W     = 2;
  localparam int OIDX_W     = 9;
  localparam int OFREE_W    = 10;
  localparam int GROUP_W    = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int QUO_W  = PAGE_BITS;
  localparam int CMP_W  = (QUO_W > LINK_W) ? QUO_W : LINK_W;

  localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPUT = 2'd2;

  localparam logic [GROUP_W-1:0] GRP_FREE    = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_PARTIAL = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_NUMBER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd3;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quotient;
    logic [SIZE_W-1:0] remainder;
  } div_res_t;

  function automatic logic [LINK_W-1:0] eff_count(input logic [SCNT_W-1:0] sc);
    if (int'(sc) > MAX_SLOTS) begin
      return LINK_W'(MAX_SLOTS);
    end
    return LINK_W'(sc);
  endfunction

  function automatic logic [GROUP_W-1:0] group_of(input logic [LINK_W-1:0] fc,
                                                  input logic [LINK_W-1:0] n);
    if (fc >= n) begin
      return GRP_FREE;
    end
    if (fc == '0) begin
      return GRP_FULL;
    end
    return GRP_PARTIAL;
  endfunction

endpackage

// ===== sv/sfia_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sfia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/sfia_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfia_div
// Restoring divider, one quotient bit per cycle, maps an in-page byte
// distance to a slot index and remainder.
// ----------------------------------------------------------------------------
module sfia_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sfia_pkg::QUO_W-1:0]       dividend,
  input  logic [sfia_pkg::SIZE_W-1:0]      divisor,
  output sfia_pkg::div_res_t               res
);

  localparam int CNT_W = $clog2(sfia_pkg::QUO_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [sfia_pkg::SIZE_W-1:0]   rem_r, rem_nxt;
  logic [sfia_pkg::QUO_W-1:0]    quo_r, quo_nxt;
  logic [sfia_pkg::SIZE_W-1:0]   dsr_r, dsr_nxt;
  logic [sfia_pkg::SIZE_W:0]     trial;
  logic [sfia_pkg::SIZE_W:0]     diff;
  logic                          ge;

  assign trial = {rem_r, quo_r[sfia_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(sfia_pkg::QUO_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[sfia_pkg::SIZE_W-1:0] : trial[sfia_pkg::SIZE_W-1:0];
      quo_nxt = {quo_r[sfia_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

// ===== sv/slab_free_index_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_free_index_allocator_core
// Free-slot list manager for one page-sized slab with address mapping.
// ----------------------------------------------------------------------------
// The free list lives in a single-port RAM of MAX_SLOTS link entries; head and
// free count are registers. One item is processed at a time and one result
// is returned per item. Init writes one link per cycle. Take reads the head
// link, then multiplies and adds the address; a take on an empty slab goes
// straight to its result. Put builds the first-slot address, checks the page,
// then divides the in-page distance by the slot size one bit a cycle; an
// address that fails the page check goes straight to its result. Unused kinds
// go straight to their result. A new item is taken while the previous result
// waits in the output register; a finished item waits until that register is
// free.
// Configuration writes are always accepted and must only occur while idle.
module slab_free_index_allocator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sfia_pkg::KIND_W-1:0]        in_kind,
  input  logic [sfia_pkg::ADDR_W-1:0]        in_object_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfia_pkg::ADDR_W-1:0]        out_slot_address,
  output logic [sfia_pkg::OIDX_W-1:0]        out_slot_index,
  output logic [sfia_pkg::OFREE_W-1:0]       out_free_slots,
  output logic [sfia_pkg::GROUP_W-1:0]       out_group,
  output logic [sfia_pkg::STAT_W-1:0]        out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfia_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfia_pkg::CFG_DATA_W-1:0]    cfg_value
);

  localparam int IDX_W  = sfia_pkg::IDX_W;
  localparam int LINK_W = sfia_pkg::LINK_W;
  localparam int ADDR_W = sfia_pkg::ADDR_W;
  localparam int PROD_W = IDX_W + sfia_pkg::SIZE_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INIT     = 8'b0000_0010,
    S_TAKE     = 8'b0000_0100,
    S_TAKE_ADR = 8'b0000_1000,
    S_PUT_BASE = 8'b0001_0000,
    S_PUT_CHK  = 8'b0010_0000,
    S_PUT_DIV  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [LINK_W-1:0]                 head_r, head_nxt;
  logic [LINK_W-1:0]                 free_r, free_nxt;
  logic [IDX_W-1:0]                  cnt_r, cnt_nxt;

  logic [sfia_pkg::PNUM_W-1:0]       page_number_r, page_number_nxt;
  logic [sfia_pkg::SIZE_W-1:0]       slot_size_r, slot_size_nxt;
  logic [sfia_pkg::SCNT_W-1:0]       slot_count_r, slot_count_nxt;
  logic [sfia_pkg::OFFS_W-1:0]       offset_r, offset_nxt;

  logic [ADDR_W-1:0]                 addr_r, addr_nxt;
  logic [ADDR_W-1:0]                 first_r, first_nxt;
  logic [PROD_W-1:0]                 prod_r, prod_nxt;
  logic [ADDR_W-1:0]                 res_addr_r, res_addr_nxt;
  logic [IDX_W-1:0]                  res_idx_r, res_idx_nxt;
  logic [sfia_pkg::STAT_W-1:0]       res_status_r, res_status_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]                 out_addr_r, out_addr_nxt;
  logic [sfia_pkg::OIDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic [sfia_pkg::OFREE_W-1:0]      out_free_r, out_free_nxt;
  logic [sfia_pkg::GROUP_W-1:0]      out_group_r, out_group_nxt;
  logic [sfia_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_addr;
  logic [LINK_W-1:0]                 ram_wdata;
  logic [LINK_W-1:0]                 ram_rdata;

  logic                              div_start;
  sfia_pkg::div_res_t                div_res;

  logic [LINK_W-1:0]                 n_eff;
  logic [ADDR_W-1:0]                 page_base;
  logic [ADDR_W:0]                   put_sub;
  logic                              put_pre_ok;
  logic                              put_ok;
  logic [LINK_W-1:0]                 cnt_inc;
  logic                              in_fire;

  assign n_eff     = sfia_pkg::eff_count(slot_count_r);
  assign page_base = ADDR_W'(page_number_r) << sfia_pkg::PAGE_BITS;
  assign put_sub   = {1'b0, addr_r} - {1'b0, first_r};
  assign put_pre_ok = (slot_size_r != '0) && !put_sub[ADDR_W] &&
      (addr_r[ADDR_W-1:sfia_pkg::PAGE_BITS] == page_base[ADDR_W-1:sfia_pkg::PAGE_BITS]);
  assign put_ok = (div_res.remainder == '0) &&
      (sfia_pkg::CMP_W'(div_res.quotient) < sfia_pkg::CMP_W'(n_eff)) &&
      (free_r < n_eff);
  assign cnt_inc = LINK_W'(cnt_r) + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign div_start = (state_r == S_PUT_CHK) && put_pre_ok;

  // free-list RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = head_r[IDX_W-1:0];
    ram_wdata = head_r;
    if (state_r == S_INIT) begin
      ram_we    = 1'b1;
      ram_addr  = cnt_r;
      ram_wdata = (cnt_inc < n_eff) ? cnt_inc : LINK_W'(sfia_pkg::MAX_SLOTS);
    end else if ((state_r == S_PUT_DIV) && div_res.done && put_ok) begin
      ram_we    = 1'b1;
      ram_addr  = div_res.quotient[IDX_W-1:0];
      ram_wdata = head_r;
    end
  end

  sfia_ram #(
    .WIDTH(LINK_W),
    .DEPTH(sfia_pkg::MAX_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sfia_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (put_sub[sfia_pkg::QUO_W-1:0]),
    .divisor  (slot_size_r),
    .res      (div_res)
  );

  // configuration
  always_comb begin
    page_number_nxt = page_number_r;
    slot_size_nxt   = slot_size_r;
    slot_count_nxt  = slot_count_r;
    offset_nxt      = offset_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sfia_pkg::CFG_PAGE_NUMBER:  page_number_nxt = cfg_value[sfia_pkg::PNUM_W-1:0];
        sfia_pkg::CFG_SLOT_SIZE:    slot_size_nxt   = cfg_value[sfia_pkg::SIZE_W-1:0];
        sfia_pkg::CFG_SLOT_COUNT:   slot_count_nxt  = cfg_value[sfia_pkg::SCNT_W-1:0];
        sfia_pkg::CFG_FIRST_OFFSET: offset_nxt      = cfg_value[sfia_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    first_nxt      = first_r;
    prod_nxt       = prod_r;
    res_addr_nxt   = res_addr_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_idx_nxt    = out_idx_r;
    out_free_nxt   = out_free_r;
    out_group_nxt  = out_group_r;
    out_status_nxt = out_status_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_addr_nxt   = '0;
          res_idx_nxt    = '0;
          res_status_nxt = sfia_pkg::ST_OK;
          priority if (in_kind == sfia_pkg::KIND_INIT) begin
            cnt_nxt = '0;
            if (n_eff == '0) begin
              head_nxt  = LINK_W'(sfia_pkg::MAX_SLOTS);
              free_nxt  = '0;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_INIT;
            end
          end else if (in_kind == sfia_pkg::KIND_TAKE) begin
            if ((free_r == '0) || (head_r >= LINK_W'(sfia_pkg::MAX_SLOTS))) begin
              res_status_nxt = sfia_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              res_idx_nxt = head_r[IDX_W-1:0];
              state_nxt   = S_TAKE;
            end
          end else if (in_kind == sfia_pkg::KIND_PUT) begin
            addr_nxt  = in_object_address;
            state_nxt = S_PUT_BASE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_inc == n_eff) begin
          head_nxt  = '0;
          free_nxt  = n_eff;
          state_nxt = S_DONE;
        end
      end
      S_TAKE: begin
        head_nxt  = ram_rdata;
        free_nxt  = free_r - 1'b1;
        prod_nxt  = PROD_W'(res_idx_r) * PROD_W'(slot_size_r);
        state_nxt = S_TAKE_ADR;
      end
      S_TAKE_ADR: begin
        res_addr_nxt = page_base + ADDR_W'(offset_r) + ADDR_W'(prod_r);
        state_nxt    = S_DONE;
      end
      S_PUT_BASE: begin
        first_nxt = page_base + ADDR_W'(offset_r);
        state_nxt = S_PUT_CHK;
      end
      S_PUT_CHK: begin
        if (put_pre_ok) begin
          state_nxt = S_PUT_DIV;
        end else begin
          res_status_nxt = sfia_pkg::ST_BADPUT;
          state_nxt      = S_DONE;
        end
      end
      S_PUT_DIV: begin
        if (div_res.done) begin
          if (put_ok) begin
            head_nxt     = LINK_W'(div_res.quotient);
            free_nxt     = free_r + 1'b1;
            res_idx_nxt  = div_res.quotient[IDX_W-1:0];
            res_addr_nxt = addr_r;
          end else begin
            res_status_nxt = sfia_pkg::ST_BADPUT;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_idx_nxt    = sfia_pkg::OIDX_W'(res_idx_r);
          out_free_nxt   = sfia_pkg::OFREE_W'(free_r);
          out_group_nxt  = sfia_pkg::group_of(free_r, n_eff);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= LINK_W'(sfia_pkg::MAX_SLOTS);
      free_r        <= '0;
      cnt_r         <= '0;
      page_number_r <= '0;
      slot_size_r   <= sfia_pkg::SIZE_W'(64);
      slot_count_r  <= sfia_pkg::SCNT_W'(32);
      offset_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      free_r        <= free_nxt;
      cnt_r         <= cnt_nxt;
      page_number_r <= page_number_nxt;
      slot_size_r   <= slot_size_nxt;
      slot_count_r  <= slot_count_nxt;
      offset_r      <= offset_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    addr_r       <= addr_nxt;
    first_r      <= first_nxt;
    prod_r       <= prod_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_idx_r    <= out_idx_nxt;
    out_free_r   <= out_free_nxt;
    out_group_r  <= out_group_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_slot_address = out_addr_r;
  assign out_slot_index   = out_idx_r;
  assign out_free_slots   = out_free_r;
  assign out_group        = out_group_r;
  assign out_status       = out_status_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted transaction did not start processing");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= LINK_W'(sfia_pkg::MAX_SLOTS))
    else $error("free count exceeds slab capacity");

  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT) || (state_r == S_PUT_DIV))
    else $error("link RAM written outside init or put");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_PUT_DIV)
    else $error("divider finished while not awaited");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sfia_pkg::ST_EMPTY) |->
      (out_slot_address == '0) && (out_slot_index == '0))
    else $error("empty take reported a slot");

endmodule

// ===== tb/slab_free_index_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_free_index_allocator_core_tb
// Self-checking bench for the slab free-index allocator. A directed part
// covers empty takes, bad put addresses, a zero slot size, an empty and a
// saturated slot count and the unused kind. Randomized phases follow, each
// with its own slab setting, mostly take/put-back traffic with some noise.
// A transaction-level model of the free list predicts every result, and
// results are compared field by field in order. Both handshakes stall in bursts.
// ----------------------------------------------------------------------------
module slab_free_index_allocator_core_tb;

  localparam int MAX_SLOTS  = sfia_pkg::MAX_SLOTS;
  localparam int PAGE_BITS  = sfia_pkg::PAGE_BITS;
  localparam int ADDR_W     = sfia_pkg::ADDR_W;
  localparam int PNUM_W     = sfia_pkg::PNUM_W;
  localparam int SIZE_W     = sfia_pkg::SIZE_W;
  localparam int SCNT_W     = sfia_pkg::SCNT_W;
  localparam int OFFS_W     = sfia_pkg::OFFS_W;
  localparam int KIND_W     = sfia_pkg::KIND_W;
  localparam int OIDX_W     = sfia_pkg::OIDX_W;
  localparam int OFREE_W    = sfia_pkg::OFREE_W;
  localparam int GROUP_W    = sfia_pkg::GROUP_W;
  localparam int STAT_W     = sfia_pkg::STAT_W;
  localparam int CFG_IDX_W  = sfia_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sfia_pkg::CFG_DATA_W;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [PNUM_W-1:0] PAGE_MAX  = '1;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
  } slab_request_t;

  typedef struct {
    logic [ADDR_W-1:0]  slot_address;
    logic [OIDX_W-1:0]  slot_index;
    logic [OFREE_W-1:0] free_slots;
    logic [GROUP_W-1:0] group;
    logic [STAT_W-1:0]  status;
  } slab_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [ADDR_W-1:0]     in_object_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     out_slot_address;
  logic [OIDX_W-1:0]     out_slot_index;
  logic [OFREE_W-1:0]    out_free_slots;
  logic [GROUP_W-1:0]    out_group;
  logic [STAT_W-1:0]     out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_value = '0;

  // free-list model state
  logic [PNUM_W-1:0] m_page = '0;
  logic [SIZE_W-1:0] m_size = 13'd64;
  logic [SCNT_W-1:0] m_count = 10'd32;
  logic [OFFS_W-1:0] m_offset = '0;
  int                link_mem [MAX_SLOTS];
  int                m_head = MAX_SLOTS;
  int                m_free = 0;

  // stimulus-side view of the slab
  logic [PNUM_W-1:0] g_page;
  logic [SIZE_W-1:0] g_size;
  logic [SCNT_W-1:0] g_count;
  logic [OFFS_W-1:0] g_offset;
  int                free_slots_q [$];
  int                taken_slots_q [$];

  slab_request_t slab_requests [$];
  slab_result_t  slab_results_due [$];
  slab_request_t req;
  slab_result_t  due;
  int            items_queued = 0;
  int            items_accepted = 0;
  int            mismatches = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  bit            bursty = 1'b1;

  slab_free_index_allocator_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_object_address (in_object_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot_address  (out_slot_address),
    .out_slot_index    (out_slot_index),
    .out_free_slots    (out_free_slots),
    .out_group         (out_group),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_value         (cfg_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void predict_slab_result(input logic [KIND_W-1:0] kind,
                                              input logic [ADDR_W-1:0] addr);
    slab_result_t      r;
    int                n;
    int                i;
    bit                ok;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] quo;
    n = (int'(m_count) > MAX_SLOTS) ? MAX_SLOTS : int'(m_count);
    r.slot_address = '0;
    r.slot_index = '0;
    r.status = sfia_pkg::ST_OK;
    base = ADDR_W'(m_page) << PAGE_BITS;
    case (kind)
      sfia_pkg::KIND_INIT: begin
        for (i = 0; i < n; i++) begin
          link_mem[i] = (i + 1 < n) ? i + 1 : MAX_SLOTS;
        end
        m_head = (n > 0) ? 0 : MAX_SLOTS;
        m_free = n;
      end
      sfia_pkg::KIND_TAKE: begin
        if (m_free == 0 || m_head >= MAX_SLOTS) begin
          r.status = sfia_pkg::ST_EMPTY;
        end else begin
          r.slot_index = OIDX_W'(m_head);
          r.slot_address = base + ADDR_W'(m_offset) + ADDR_W'(m_head) * ADDR_W'(m_size);
          m_head = link_mem[m_head];
          m_free--;
        end
      end
      sfia_pkg::KIND_PUT: begin
        first = base + ADDR_W'(m_offset);
        ok = (m_size != '0) && (addr >= first);
        if (ok && (addr >> PAGE_BITS) != (base >> PAGE_BITS)) begin
          ok = 1'b0;
        end
        if (ok) begin
          diff = addr - first;
          quo = diff / ADDR_W'(m_size);
          if (diff % ADDR_W'(m_size) != '0) begin
            ok = 1'b0;
          end
          if (quo >= ADDR_W'(n)) begin
            ok = 1'b0;
          end
        end
        if (ok && m_free >= n) begin
          ok = 1'b0;
        end
        if (ok) begin
          link_mem[quo] = m_head;
          m_head = int'(quo);
          m_free++;
          r.slot_index = OIDX_W'(quo);
          r.slot_address = addr;
        end else begin
          r.status = sfia_pkg::ST_BADPUT;
        end
      end
      default: begin
      end
    endcase
    r.free_slots = OFREE_W'(m_free);
    if (m_free >= n) begin
      r.group = sfia_pkg::GRP_FREE;
    end else if (m_free == 0) begin
      r.group = sfia_pkg::GRP_FULL;
    end else begin
      r.group = sfia_pkg::GRP_PARTIAL;
    end
    slab_results_due.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfia_pkg::CFG_PAGE_NUMBER:  m_page = cfg_value[PNUM_W-1:0];
        sfia_pkg::CFG_SLOT_SIZE:    m_size = cfg_value[SIZE_W-1:0];
        sfia_pkg::CFG_SLOT_COUNT:   m_count = cfg_value[SCNT_W-1:0];
        sfia_pkg::CFG_FIRST_OFFSET: m_offset = cfg_value[OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_slab_result(in_kind, in_object_address);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bursty && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (slab_requests.size() > 0) begin
          req = slab_requests.pop_front();
          in_valid <= 1'b1;
          in_kind <= req.kind;
          in_object_address <= req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (slab_results_due.size() == 0) begin
          $error("unexpected transaction: slot_address %h status %0d",
                 out_slot_address, out_status);
          mismatches++;
        end else begin
          due = slab_results_due.pop_front();
          if (out_slot_address !== due.slot_address) begin
            $error("slot_address expected %h actual %h", due.slot_address, out_slot_address);
            mismatches++;
          end
          if (out_slot_index !== due.slot_index) begin
            $error("slot_index expected %0d actual %0d", due.slot_index, out_slot_index);
            mismatches++;
          end
          if (out_free_slots !== due.free_slots) begin
            $error("free_slots expected %0d actual %0d", due.free_slots, out_free_slots);
            mismatches++;
          end
          if (out_group !== due.group) begin
            $error("group expected %0d actual %0d", due.group, out_group);
            mismatches++;
          end
          if (out_status !== due.status) begin
            $error("status expected %0d actual %0d", due.status, out_status);
            mismatches++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input int idx);
    return (ADDR_W'(g_page) << PAGE_BITS) + ADDR_W'(g_offset) + ADDR_W'(idx) * ADDR_W'(g_size);
  endfunction

  function automatic bit slot_fits(input int idx, input int n);
    return g_size != '0 && idx < n && (int'(g_offset) + idx * int'(g_size)) < (1 << PAGE_BITS);
  endfunction

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    slab_request_t r;
    r.kind = kind;
    r.addr = addr;
    slab_requests.push_back(r);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || slab_results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_slab_config(input logic [PNUM_W-1:0] page, input logic [SIZE_W-1:0] size,
                                 input logic [SCNT_W-1:0] count,
                                 input logic [OFFS_W-1:0] offset);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(sfia_pkg::CFG_PAGE_NUMBER, CFG_DATA_W'(page));
    write_reg(sfia_pkg::CFG_SLOT_SIZE, CFG_DATA_W'(size));
    write_reg(sfia_pkg::CFG_SLOT_COUNT, CFG_DATA_W'(count));
    write_reg(sfia_pkg::CFG_FIRST_OFFSET, CFG_DATA_W'(offset));
    cfg_valid <= 1'b0;
    g_page = page;
    g_size = size;
    g_count = count;
    g_offset = offset;
  endtask

  task automatic queue_init(input int n);
    int i;
    queue_item(sfia_pkg::KIND_INIT, rand_addr());
    free_slots_q = {};
    taken_slots_q = {};
    for (i = 0; i < n; i++) begin
      free_slots_q.push_back(i);
    end
  endtask

  task automatic queue_slab_traffic(input int count);
    int                n;
    int                k;
    int                sel;
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] base;
    n = (int'(g_count) > MAX_SLOTS) ? MAX_SLOTS : int'(g_count);
    base = ADDR_W'(g_page) << PAGE_BITS;
    queue_init(n);
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        queue_init(n);
      end else if (sel < 5) begin
        queue_item(KIND_NONE, rand_addr());
      end else if (sel < 50 || (sel < 85 && taken_slots_q.size() == 0)) begin
        queue_item(sfia_pkg::KIND_TAKE, rand_addr());
        if (free_slots_q.size() > 0) begin
          taken_slots_q.push_back(free_slots_q.pop_front());
        end
      end else if (sel < 85) begin
        pick = $urandom_range(0, taken_slots_q.size() - 1);
        idx = taken_slots_q[pick];
        queue_item(sfia_pkg::KIND_PUT, slot_addr(idx));
        if (slot_fits(idx, n) && free_slots_q.size() < n) begin
          taken_slots_q.delete(pick);
          free_slots_q.push_front(idx);
        end
      end else begin
        idx = $urandom_range(0, (n > 0) ? n - 1 : 0);
        case ($urandom_range(0, 5))
          0: queue_item(sfia_pkg::KIND_PUT, rand_addr());
          1: queue_item(sfia_pkg::KIND_PUT, (g_size > 1) ?
                        slot_addr(idx) + ADDR_W'($urandom_range(1, g_size - 1)) : rand_addr());
          2: queue_item(sfia_pkg::KIND_PUT, (g_offset > 0) ?
                        base + ADDR_W'($urandom_range(0, g_offset - 1)) :
                        base - 1 - ADDR_W'($urandom_range(0, 1000)));
          3: queue_item(sfia_pkg::KIND_PUT,
                        slot_addr(idx) ^ (64'd1 << $urandom_range(PAGE_BITS, 63)));
          4: queue_item(sfia_pkg::KIND_PUT, slot_addr(n + $urandom_range(0, 7)));
          default: begin
            // put back a slot that is already free
            if (free_slots_q.size() > 0) begin
              idx = free_slots_q[$urandom_range(0, free_slots_q.size() - 1)];
            end
            queue_item(sfia_pkg::KIND_PUT, slot_addr(idx));
            if (slot_fits(idx, n) && free_slots_q.size() < n) begin
              free_slots_q.push_front(idx);
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [PNUM_W-1:0] page;
    logic [SIZE_W-1:0] size;
    logic [SCNT_W-1:0] count;
    logic [OFFS_W-1:0] offset;
    int                p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: take and put before init, unused kind, bad put addresses
    set_slab_config('0, 13'd64, 10'd32, '0);
    queue_item(sfia_pkg::KIND_TAKE, '0);
    queue_item(sfia_pkg::KIND_PUT, '0);
    queue_item(KIND_NONE, '1);
    queue_item(sfia_pkg::KIND_INIT, '0);
    queue_item(sfia_pkg::KIND_TAKE, '0);
    queue_item(sfia_pkg::KIND_PUT, 64'd0);
    queue_item(sfia_pkg::KIND_PUT, 64'd1);
    queue_item(sfia_pkg::KIND_PUT, 64'h5000);
    queue_item(sfia_pkg::KIND_PUT, 64'd2048);
    queue_item(sfia_pkg::KIND_PUT, 64'd0);

    // top page, largest slot and offset, one slot: full and empty slab
    set_slab_config(PAGE_MAX, 13'd4096, 10'd1, 12'hfff);
    queue_item(sfia_pkg::KIND_INIT, '1);
    queue_item(sfia_pkg::KIND_TAKE, '1);
    queue_item(sfia_pkg::KIND_TAKE, '0);
    queue_item(sfia_pkg::KIND_PUT, 64'hffff_ffff_ffff_f000);
    queue_item(sfia_pkg::KIND_PUT, '1);
    queue_item(sfia_pkg::KIND_PUT, '1);

    // zero slot size, then zero slot count
    set_slab_config(52'd7, 13'd0, 10'd3, 12'd5);
    queue_item(sfia_pkg::KIND_INIT, '0);
    queue_item(sfia_pkg::KIND_TAKE, '0);
    queue_item(sfia_pkg::KIND_PUT, 64'h7005);
    set_slab_config(52'd7, 13'd0, 10'd0, 12'd5);
    queue_item(sfia_pkg::KIND_INIT, '0);
    queue_item(sfia_pkg::KIND_TAKE, '0);
    queue_item(sfia_pkg::KIND_PUT, 64'h7005);

    // slot count beyond the store size
    set_slab_config(PNUM_W'({$urandom, $urandom}), 13'd1, 10'd1023, '0);
    queue_slab_traffic(60);

    for (p = 0; p < 7; p++) begin
      case ($urandom_range(0, 3))
        0: page = '0;
        1: page = PAGE_MAX;
        default: page = PNUM_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 4))
        0: size = 13'd1;
        1: size = 13'd4096;
        2: size = 13'd1 << $urandom_range(0, 12);
        3: size = SIZE_W'($urandom_range(1, 4096));
        default: size = SIZE_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 3))
        0: offset = '0;
        1: offset = 12'hfff;
        default: offset = OFFS_W'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 9))
        0: count = 10'd512;
        1: count = SCNT_W'($urandom_range(513, 1023));
        2: count = '0;
        3: count = SCNT_W'($urandom_range(1, 4));
        default: count = SCNT_W'($urandom_range(1, 48));
      endcase
      set_slab_config(page, size, count, offset);
      bursty = (p == 6) ? 1'b0 : ($urandom_range(0, 2) != 0);
      queue_slab_traffic(95);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS slab_free_index_allocator_core");
    end else begin
      $display("FAIL slab_free_index_allocator_core");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL slab_free_index_allocator_core");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sfia_pkg.sv
sv/sfia_ram.sv
sv/sfia_div.sv
sv/slab_free_index_allocator_core.sv
tb/slab_free_index_allocator_core_tb.sv
